>>> hw/rtl/lpse_pkg.sv
// ----------------------------------------------------------------------------
// lpse_pkg - shared types and constants for the LED pixel symbol encoder
// Register indexes, color codes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package lpse_pkg;

	localparam int MAX_SLOTS_DEF = 5;
	localparam int TICK_BITS_DEF = 15;

	localparam int TICK_W      = 15;  // width of the tick fields on the wire
	localparam int BYTE_W      = 8;
	localparam int NUM_COLORS  = 5;
	localparam int SLOT_CODE_W = 3;
	localparam int ORDER_W     = 15;
	localparam int NBYTES_W    = 3;
	localparam int BIT_IDX_W   = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int MIN_BYTES   = 3;
	localparam int TOP_BIT     = 7;

	localparam int IN_TDATA_W  = NUM_COLORS * BYTE_W;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_ORDER   = 3'd0,
		REG_BYTES_PER_PIXEL = 3'd1,
		REG_ZERO_HIGH_TICKS = 3'd2,
		REG_ZERO_LOW_TICKS  = 3'd3,
		REG_ONE_HIGH_TICKS  = 3'd4,
		REG_ONE_LOW_TICKS   = 3'd5
	} cfg_reg_t;

	typedef enum logic [SLOT_CODE_W-1:0] {
		COLOR_RED   = 3'd0,
		COLOR_GREEN = 3'd1,
		COLOR_BLUE  = 3'd2,
		COLOR_WHITE = 3'd3,
		COLOR_COOL  = 3'd4
	} color_code_t;

	// Effective configuration as seen by the symbol generator
	typedef struct packed {
		logic [ORDER_W-1:0]  channel_order;
		logic [NBYTES_W-1:0] num_bytes;     // already clamped
		logic [TICK_W-1:0]   zero_high;
		logic [TICK_W-1:0]   zero_low;
		logic [TICK_W-1:0]   one_high;
		logic [TICK_W-1:0]   one_low;
	} cfg_t;

endpackage

>>> hw/rtl/lpse_cfg.sv
// ----------------------------------------------------------------------------
// lpse_cfg - configuration register file
// Takes index/data writes, holds the six registers and presents the
// effective settings (clamped byte count, masked tick counts).
// ----------------------------------------------------------------------------
module lpse_cfg #(
	parameter int MAX_SLOTS = lpse_pkg::MAX_SLOTS_DEF,
	parameter int TICK_BITS = lpse_pkg::TICK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [lpse_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [lpse_pkg::TICK_W-1:0]     wr_data,
	output lpse_pkg::cfg_t                  cfg
);

	logic [lpse_pkg::ORDER_W-1:0]  order_q;
	logic [lpse_pkg::NBYTES_W-1:0] nbytes_q;
	logic [TICK_BITS-1:0]          zero_high_q;
	logic [TICK_BITS-1:0]          zero_low_q;
	logic [TICK_BITS-1:0]          one_high_q;
	logic [TICK_BITS-1:0]          one_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= lpse_pkg::ORDER_W'(129);
			nbytes_q    <= lpse_pkg::NBYTES_W'(3);
			zero_high_q <= TICK_BITS'(26);
			zero_low_q  <= TICK_BITS'(70);
			one_high_q  <= TICK_BITS'(51);
			one_low_q   <= TICK_BITS'(45);
		end else if (wr_en) begin
			unique case (wr_index)
				lpse_pkg::REG_CHANNEL_ORDER:   order_q     <= wr_data;
				lpse_pkg::REG_BYTES_PER_PIXEL: nbytes_q    <= wr_data[lpse_pkg::NBYTES_W-1:0];
				lpse_pkg::REG_ZERO_HIGH_TICKS: zero_high_q <= TICK_BITS'(wr_data);
				lpse_pkg::REG_ZERO_LOW_TICKS:  zero_low_q  <= TICK_BITS'(wr_data);
				lpse_pkg::REG_ONE_HIGH_TICKS:  one_high_q  <= TICK_BITS'(wr_data);
				lpse_pkg::REG_ONE_LOW_TICKS:   one_low_q   <= TICK_BITS'(wr_data);
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	always_comb begin
		cfg.channel_order = order_q;
		if (nbytes_q < lpse_pkg::NBYTES_W'(lpse_pkg::MIN_BYTES))
			cfg.num_bytes = lpse_pkg::NBYTES_W'(lpse_pkg::MIN_BYTES);
		else if (nbytes_q > lpse_pkg::NBYTES_W'(MAX_SLOTS))
			cfg.num_bytes = lpse_pkg::NBYTES_W'(MAX_SLOTS);
		else
			cfg.num_bytes = nbytes_q;
		cfg.zero_high = lpse_pkg::TICK_W'(zero_high_q);
		cfg.zero_low  = lpse_pkg::TICK_W'(zero_low_q);
		cfg.one_high  = lpse_pkg::TICK_W'(one_high_q);
		cfg.one_low   = lpse_pkg::TICK_W'(one_low_q);
	end

endmodule

>>> hw/rtl/lpse_sym.sv
// ----------------------------------------------------------------------------
// lpse_sym - pixel holding register, bit walker and symbol output register
// Walks the selected color bytes MSB first, one symbol per cycle while the output is ready.
// ----------------------------------------------------------------------------
module lpse_sym #(
	parameter int MAX_SLOTS = lpse_pkg::MAX_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lpse_pkg::cfg_t                     cfg,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  logic [lpse_pkg::IN_TDATA_W-1:0]    pix_data,
	output logic                               sym_valid,
	input  logic                               sym_ready,
	output logic                               sym_bit,
	output logic [lpse_pkg::TICK_W-1:0]        sym_high,
	output logic [lpse_pkg::TICK_W-1:0]        sym_low,
	output logic                               sym_last
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic [lpse_pkg::IN_TDATA_W-1:0]  pix_q;
	logic                             pix_vld_q;
	logic [SLOT_W-1:0]                slot_q;
	logic [lpse_pkg::BIT_IDX_W-1:0]   bit_q;

	logic                             out_vld_q;
	logic                             out_bit_q;
	logic [lpse_pkg::TICK_W-1:0]      out_high_q;
	logic [lpse_pkg::TICK_W-1:0]      out_low_q;
	logic                             out_last_q;

	logic                                 load;
	logic                                 at_last;
	logic                                 pix_acc;
	logic [lpse_pkg::SLOT_CODE_W-1:0]     code;
	logic [lpse_pkg::BYTE_W-1:0]          sel_byte;
	logic                                 cur_bit;

	assign load    = pix_vld_q && (!out_vld_q || sym_ready);
	assign at_last = (lpse_pkg::NBYTES_W'(slot_q) == cfg.num_bytes - lpse_pkg::NBYTES_W'(1))
		&& (bit_q == '0);
	// next pixel may enter while the last symbol of this one goes out
	assign pix_ready = !pix_vld_q || (load && at_last);
	assign pix_acc   = pix_valid && pix_ready;

	always_comb begin
		code = cfg.channel_order[slot_q * lpse_pkg::SLOT_CODE_W +: lpse_pkg::SLOT_CODE_W];
		case (code)
			lpse_pkg::COLOR_GREEN: sel_byte = pix_q[1*lpse_pkg::BYTE_W +: lpse_pkg::BYTE_W];
			lpse_pkg::COLOR_BLUE:  sel_byte = pix_q[2*lpse_pkg::BYTE_W +: lpse_pkg::BYTE_W];
			lpse_pkg::COLOR_WHITE: sel_byte = pix_q[3*lpse_pkg::BYTE_W +: lpse_pkg::BYTE_W];
			lpse_pkg::COLOR_COOL:  sel_byte = pix_q[4*lpse_pkg::BYTE_W +: lpse_pkg::BYTE_W];
			default:               sel_byte = pix_q[0 +: lpse_pkg::BYTE_W]; // red, also bad codes
		endcase
		cur_bit = sel_byte[bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_q <= 1'b0;
			slot_q    <= '0;
			bit_q     <= lpse_pkg::BIT_IDX_W'(lpse_pkg::TOP_BIT);
		end else if (pix_acc) begin
			pix_vld_q <= 1'b1;
			slot_q    <= '0;
			bit_q     <= lpse_pkg::BIT_IDX_W'(lpse_pkg::TOP_BIT);
		end else if (load) begin
			if (at_last) begin
				pix_vld_q <= 1'b0;
			end else if (bit_q == '0) begin
				bit_q  <= lpse_pkg::BIT_IDX_W'(lpse_pkg::TOP_BIT);
				slot_q <= slot_q + SLOT_W'(1);
			end else begin
				bit_q <= bit_q - lpse_pkg::BIT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc)
			pix_q <= pix_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (sym_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_bit_q  <= cur_bit;
			out_high_q <= cur_bit ? cfg.one_high : cfg.zero_high;
			out_low_q  <= cur_bit ? cfg.one_low : cfg.zero_low;
			out_last_q <= at_last;
		end
	end

	assign sym_valid = out_vld_q;
	assign sym_bit   = out_bit_q;
	assign sym_high  = out_high_q;
	assign sym_low   = out_low_q;
	assign sym_last  = out_last_q;

	a_start_msb: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> (slot_q == '0) && (bit_q == lpse_pkg::BIT_IDX_W'(lpse_pkg::TOP_BIT)))
		else $error("new pixel does not start at slot 0, MSB");

	a_hold_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !at_last) |=> pix_vld_q)
		else $error("pixel dropped before its last symbol");

	a_retire_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(load && at_last && !pix_valid) |=> !pix_vld_q)
		else $error("pixel kept after its last symbol");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_vld_q |-> (lpse_pkg::NBYTES_W'(slot_q) < cfg.num_bytes))
		else $error("slot index beyond byte count");

endmodule

>>> hw/rtl/led_pixel_symbol_encoder_top.sv
// ----------------------------------------------------------------------------
// led_pixel_symbol_encoder_top - pixel to LED pulse symbol encoder
// Turns one five-byte pixel into a stream of per-bit pulse symbols.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request: red, green, blue, white, cool white.
//   m_axis carries one symbol per request: the data bit and its high/low tick
//   counts; tlast marks the final symbol of the pixel.
//   cfg_* writes a register by index; it is always ready. Change settings only
//   while no pixel is in flight.
// Timing:
//   A pixel yields 8 * bytes_per_pixel symbols (24 to 40), one per cycle while
//   m_axis is ready; the bit walker emits them in turn. The pixel is first
//   registered in the holding register, then each symbol in the symbol
//   register. The next pixel is taken in the cycle the last symbol of
//   the current one is loaded, so pixels stream with no gap.
// Reset:
//   arst_n clears the pipeline and loads the default order (green, red, blue),
//   three bytes per pixel and the default tick counts.
// Stall:
//   With m_axis_tready low the symbol register holds and the walker waits;
//   s_axis_tready drops while a pixel is still being walked.
// ----------------------------------------------------------------------------
module led_pixel_symbol_encoder_top #(
	parameter int MAX_SLOTS = lpse_pkg::MAX_SLOTS_DEF,
	parameter int TICK_BITS = lpse_pkg::TICK_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lpse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpse_pkg::TICK_W-1:0]          cfg_data,
	// pixel input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// color_red[7:0], color_green[15:8], color_blue[23:16],
	// color_white[31:24], color_cool[39:32]
	input  logic [lpse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// symbol output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// bit_value[0], high_ticks[15:1], low_ticks[30:16], zero pad[31]
	output logic [lpse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast    // last_symbol
);

	lpse_pkg::cfg_t               cfg;
	logic                         sym_bit;
	logic [lpse_pkg::TICK_W-1:0]  sym_high;
	logic [lpse_pkg::TICK_W-1:0]  sym_low;

	assign cfg_ready = 1'b1;

	lpse_cfg #(
		.MAX_SLOTS (MAX_SLOTS),
		.TICK_BITS (TICK_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lpse_sym #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_sym (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (s_axis_tvalid),
		.pix_ready (s_axis_tready),
		.pix_data  (s_axis_tdata),
		.sym_valid (m_axis_tvalid),
		.sym_ready (m_axis_tready),
		.sym_bit   (sym_bit),
		.sym_high  (sym_high),
		.sym_low   (sym_low),
		.sym_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, sym_low, sym_high, sym_bit};

endmodule
